### hw/rtl/lz4_block_decompressor_core_assert.svh
// Assertion macros shared by the decompressor RTL.
// Each macro expands to one labelled concurrent assertion, clocked on the
// rising edge and switched off while reset is high.
`ifndef LZ4_BLOCK_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZ4_BLOCK_DECOMPRESSOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZ4D_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lz4 decompressor check failed");

// Consequent must hold in the cycle after the antecedent.
`define LZ4D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lz4 decompressor check failed");

`endif

### hw/rtl/lz4d_pkg.sv
// ----------------------------------------------------------------------------
// LZ4 block decompressor package
// Status codes, LZ4 format constants and field widths used by the core.
// ----------------------------------------------------------------------------
package lz4d_pkg;

  // Field widths of the stream words.
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 24;
  localparam int CAP_W    = 24;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_RUN    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADOFF = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd5;

  // Input word kinds carried on tuser.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // LZ4 format constants.
  localparam logic [3:0] NIBBLE_EXT   = 4'hF;   // nibble value that asks for more length bytes
  localparam logic [7:0] BYTE_EXT     = 8'hFF;  // length byte that is followed by another
  localparam logic [2:0] MATCH_MIN    = 3'd4;   // smallest match length

  typedef logic [STATUS_W-1:0] status_t;

endpackage

### hw/rtl/lz4d_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module lz4d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lz4_block_decompressor_core.sv
// ----------------------------------------------------------------------------
// LZ4 block decompressor core
// Parses an LZ4 block one compressed byte per word, emits literals and copies
// match bytes out of a history RAM, one byte per copy tick word.
//
//   Channel  Dir  Handshake          Payload
//   s_*      in   s_tvalid/s_tready  tdata: in_byte, tuser: req_type, tlast: in_last
//   m_*      out  m_tvalid/m_tready  tdata: out_byte..out_total, tuser: out_valid
//   cfg_*    in   cfg_valid/cfg_ready cfg_data: out_capacity
//
// One input word per cycle while the output register can take it, one result
// word per input word, registered and shown in the cycle after acceptance.
// The history RAM has one read and one write port; a byte is written in the
// cycle after its parse and forwarded to a read of that entry in that cycle.
// The result sits in an output register; a new word is taken while that
// register is empty or being drained in the same cycle.
// Reset is synchronous; the history RAM is not cleared, since a match only
// reaches bytes written earlier in the same block.
// ----------------------------------------------------------------------------
`include "lz4_block_decompressor_core_assert.svh"

module lz4_block_decompressor_core
  import lz4d_pkg::*;
#(
  parameter int WINDOW_BYTES = 65536,
  parameter int COUNT_BITS   = 24
) (
  input  logic              clk,
  input  logic              rst,
  // Compressed input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] in_byte
  input  logic              s_tuser,   // [0] req_type
  input  logic              s_tlast,   // in_last
  // Decompressed result stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // [7:0] out_byte, [8] copy_pending,
                                       // [11:9] status, [35:12] out_total, rest zero
  output logic              m_tuser,   // [0] out_valid
  // Capacity register write.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int CB = COUNT_BITS;
  localparam int SW = (CB + 2 > CAP_W) ? CB + 2 : CAP_W;

  // Parser phases.
  localparam logic [2:0] PH_TOKEN    = 3'd0;
  localparam logic [2:0] PH_LITLEN   = 3'd1;
  localparam logic [2:0] PH_LIT      = 3'd2;
  localparam logic [2:0] PH_OFFLO    = 3'd3;
  localparam logic [2:0] PH_OFFHI    = 3'd4;
  localparam logic [2:0] PH_MATLEN   = 3'd5;
  localparam logic [2:0] PH_COPY     = 3'd6;
  localparam logic [2:0] PH_COPY_END = 3'd7;

  localparam logic [SW-1:0] COUNT_MAX = {{(SW-CB){1'b0}}, {CB{1'b1}}};

  // Parser state.
  logic [2:0]    phase;
  logic [CB-1:0] literal_left;
  logic [CB-1:0] match_left;
  logic [3:0]    match_nibble;
  logic [15:0]   offset_reg;
  logic [CB-1:0] produced_count;
  logic [AW-1:0] wr_ptr;
  logic [SW-1:0] limit;

  // Output stage.
  logic          s1_valid;
  logic          s1_first;
  logic          s1_vld;
  logic          s1_copy;
  logic          s1_fwd;
  logic [7:0]    s1_lit;
  logic          s1_pending;
  status_t       s1_status;
  logic [TOTAL_W-1:0] s1_total;
  logic [AW-1:0] s1_waddr;
  logic [7:0]    fwd_byte;

  // Step logic.
  logic          accept;
  logic          copying;
  logic [2:0]    phase_next;
  logic [CB-1:0] literal_left_next;
  logic [CB-1:0] match_left_next;
  logic [3:0]    match_nibble_next;
  logic [15:0]   offset_reg_next;
  logic [CB-1:0] produced_count_next;
  logic [AW-1:0] wr_ptr_next;
  status_t       st;
  logic          vld;
  logic          is_copy;
  logic [7:0]    lit_byte;
  logic [15:0]   off_full;
  logic          bad_off;
  logic [SW-1:0] len_sum;
  logic          over;
  logic [AW:0]   rd_x;
  logic [AW-1:0] rd_addr;
  logic          fwd_now;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [7:0]    cur_byte;
  logic [SW-1:0] cap_sw;
  logic [SW-1:0] total_sw;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !s1_valid || m_tready;
  assign cfg_ready = 1'b1;
  assign copying   = (phase == PH_COPY) || (phase == PH_COPY_END);

  // Capacity limit, clipped to the counter range.
  assign cap_sw = SW'(cfg_data);
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= (SW'({CAP_W{1'b1}}) < COUNT_MAX) ? SW'({CAP_W{1'b1}}) : COUNT_MAX;
    end else if (cfg_valid && cfg_ready) begin
      limit <= (cap_sw < COUNT_MAX) ? cap_sw : COUNT_MAX;
    end
  end

  // Offset check against the bytes produced so far and the window.
  assign off_full = {s_tdata, offset_reg[7:0]};
  assign bad_off  = (off_full == 16'd0) ||
                    (SW'(off_full) > SW'(produced_count)) ||
                    (17'(off_full) > 17'(WINDOW_BYTES));

  // One shared length check: the length that is known after this byte.
  always_comb begin
    case (phase)
      PH_TOKEN:  len_sum = SW'(s_tdata[7:4]);
      PH_LITLEN: len_sum = SW'(literal_left) + SW'(s_tdata);
      PH_OFFHI:  len_sum = SW'(match_nibble) + SW'(MATCH_MIN);
      PH_MATLEN: len_sum = SW'(match_left) + SW'(s_tdata);
      default:   len_sum = '0;
    endcase
  end
  assign over = (SW'(produced_count) + len_sum) > limit;

  // Parser next state.
  always_comb begin
    phase_next        = phase;
    literal_left_next = literal_left;
    match_left_next   = match_left;
    match_nibble_next = match_nibble;
    offset_reg_next   = offset_reg;
    st                = ST_RUN;
    vld               = 1'b0;
    is_copy           = 1'b0;
    lit_byte          = '0;
    if (s_tuser == REQ_TICK) begin
      if (copying) begin
        vld             = 1'b1;
        is_copy         = 1'b1;
        match_left_next = match_left - CB'(1);
        if (match_left_next == '0) begin
          if (phase == PH_COPY_END) begin
            st = ST_OK;
          end else begin
            phase_next = PH_TOKEN;
          end
        end
      end
    end else if (copying) begin
      st = ST_BUSY;
    end else begin
      case (phase)
        PH_TOKEN: begin
          match_nibble_next = s_tdata[3:0];
          literal_left_next = CB'(s_tdata[7:4]);
          if (s_tdata[7:4] != 4'd0) begin
            if (over) begin
              st = ST_OVER;
            end else if (s_tlast) begin
              st = ST_TRUNC;
            end else begin
              phase_next = (s_tdata[7:4] == NIBBLE_EXT) ? PH_LITLEN : PH_LIT;
            end
          end else if (s_tlast) begin
            st = ST_OK;
          end else begin
            phase_next = PH_OFFLO;
          end
        end
        PH_LITLEN: begin
          literal_left_next = len_sum[CB-1:0];
          if (over) begin
            st = ST_OVER;
          end else if (s_tlast) begin
            st = ST_TRUNC;
          end else if (s_tdata != BYTE_EXT) begin
            phase_next = PH_LIT;
          end
        end
        PH_LIT: begin
          vld               = 1'b1;
          lit_byte          = s_tdata;
          literal_left_next = literal_left - CB'(1);
          if (literal_left_next == '0) begin
            if (s_tlast) begin
              st = ST_OK;
            end else begin
              phase_next = PH_OFFLO;
            end
          end else if (s_tlast) begin
            st = ST_TRUNC;
          end
        end
        PH_OFFLO: begin
          offset_reg_next = {8'd0, s_tdata};
          if (s_tlast) begin
            st = ST_TRUNC;
          end else begin
            phase_next = PH_OFFHI;
          end
        end
        PH_OFFHI: begin
          offset_reg_next = off_full;
          if (bad_off) begin
            st = ST_BADOFF;
          end else begin
            match_left_next = len_sum[CB-1:0];
            if (over) begin
              st = ST_OVER;
            end else if (match_nibble == NIBBLE_EXT) begin
              if (s_tlast) begin
                st = ST_TRUNC;
              end else begin
                phase_next = PH_MATLEN;
              end
            end else begin
              phase_next = s_tlast ? PH_COPY_END : PH_COPY;
            end
          end
        end
        PH_MATLEN: begin
          match_left_next = len_sum[CB-1:0];
          if (over) begin
            st = ST_OVER;
          end else if (s_tdata == BYTE_EXT) begin
            if (s_tlast) begin
              st = ST_TRUNC;
            end
          end else begin
            phase_next = s_tlast ? PH_COPY_END : PH_COPY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Byte count and history write pointer, wrapping at the window size.
  assign produced_count_next = produced_count + CB'(vld);
  assign wr_ptr_next = !vld ? wr_ptr :
                       (wr_ptr == AW'(WINDOW_BYTES - 1)) ? '0 : wr_ptr + AW'(1);

  // Source entry of a match byte, behind the write pointer by the offset.
  always_comb begin
    if ((AW+1)'(wr_ptr) >= (AW+1)'(offset_reg)) begin
      rd_x = (AW+1)'(wr_ptr) - (AW+1)'(offset_reg);
    end else begin
      rd_x = (AW+1)'(wr_ptr) + (AW+1)'(WINDOW_BYTES) - (AW+1)'(offset_reg);
    end
  end
  assign rd_addr = rd_x[AW-1:0];

  // The byte of the word in the output stage is written in its first cycle,
  // the same cycle in which the next word may read that entry.
  assign ram_we  = s1_valid && s1_first && s1_vld;
  assign fwd_now = ram_we && (rd_addr == s1_waddr);
  assign cur_byte = s1_copy ? (s1_fwd ? fwd_byte : ram_rdata) : s1_lit;

  lz4d_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_BYTES)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_waddr),
    .wdata (cur_byte),
    .re    (accept && is_copy),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Parser state registers; an ending status starts a fresh block.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TOKEN;
      literal_left   <= '0;
      match_left     <= '0;
      match_nibble   <= '0;
      offset_reg     <= '0;
      produced_count <= '0;
      wr_ptr         <= '0;
    end else if (accept) begin
      if (st != ST_RUN) begin
        phase          <= PH_TOKEN;
        literal_left   <= '0;
        match_left     <= '0;
        match_nibble   <= '0;
        offset_reg     <= '0;
        produced_count <= '0;
        wr_ptr         <= '0;
      end else begin
        phase          <= phase_next;
        literal_left   <= literal_left_next;
        match_left     <= match_left_next;
        match_nibble   <= match_nibble_next;
        offset_reg     <= offset_reg_next;
        produced_count <= produced_count_next;
        wr_ptr         <= wr_ptr_next;
      end
    end
  end

  // Output stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_first <= 1'b0;
    end else begin
      s1_first <= accept;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (m_tready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Output stage payload.
  assign total_sw = SW'(produced_count_next);
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_vld     <= vld;
      s1_copy    <= is_copy;
      s1_fwd     <= is_copy && fwd_now;
      s1_lit     <= lit_byte;
      s1_status  <= st;
      s1_pending <= (st == ST_RUN) &&
                    ((phase_next == PH_COPY) || (phase_next == PH_COPY_END));
      s1_total   <= total_sw[TOTAL_W-1:0];
      s1_waddr   <= wr_ptr;
      fwd_byte   <= cur_byte;
    end
  end

  assign m_tvalid = s1_valid;
  assign m_tuser  = s1_vld;
  assign m_tdata  = {4'd0, s1_total, s1_status, s1_pending, cur_byte};

  // Checks on the parser and the output stage.
  `LZ4D_ASSERT_NEXT(a_block_end_clears, clk, rst,
                    accept && (st != ST_RUN), (phase == PH_TOKEN) && (produced_count == '0))
  `LZ4D_ASSERT_NOW(a_copy_has_bytes, clk, rst, copying, match_left != '0)
  `LZ4D_ASSERT_NOW(a_end_not_pending, clk, rst,
                   s1_valid && (s1_status != ST_RUN), !s1_pending)

endmodule
